FILE: rtl/kthsucc_pkg.sv
package kthsucc_pkg;

  localparam int unsigned NodeW  = 10;
  localparam int unsigned StepW  = 31;
  localparam int unsigned CountW = 11;
  localparam int unsigned DefMaxNodes = 1024;
  localparam int unsigned DefLevels   = 31;
  localparam logic [CountW-1:0] CountReset = 11'd1024;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_BUILD = 2'd1,
    OP_QUERY = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef struct packed {
    logic [1:0]       operation;
    logic [NodeW-1:0] node_index;
    logic [NodeW-1:0] successor_node;
    logic [StepW-1:0] step_count;
  } in_item_t;

  typedef struct packed {
    logic [NodeW-1:0] destination_node;
    logic             index_error;
  } out_item_t;

  // node travelling down the row of cells
  typedef struct packed {
    logic             valid;
    logic [NodeW-1:0] pos;
  } link_t;

  // table write and build read control into one cell
  typedef struct packed {
    logic             wr_en;
    logic [NodeW-1:0] wr_addr;
    logic [NodeW-1:0] wr_data;
    logic             bld_sel;
    logic [NodeW-1:0] bld_addr;
  } cell_ctrl_t;

endpackage

FILE: rtl/kthsucc_cell.sv
module kthsucc_cell #(
  parameter int unsigned MAX_NODES = kthsucc_pkg::DefMaxNodes
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  kthsucc_pkg::link_t                  link_i,
  input  logic                                step_i,
  input  kthsucc_pkg::cell_ctrl_t             ctrl_i,
  output kthsucc_pkg::link_t                  link_o,
  output logic [kthsucc_pkg::NodeW-1:0]       rdata_o
);

  localparam int unsigned AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;

  logic [kthsucc_pkg::NodeW-1:0] mem [MAX_NODES];
  logic [kthsucc_pkg::NodeW-1:0] rdata_q;
  logic [kthsucc_pkg::NodeW-1:0] pos_q;
  logic                          step_q;
  logic                          valid_q;
  logic [AW-1:0]                 raddr;

  assign raddr = ctrl_i.bld_sel ? AW'(ctrl_i.bld_addr) : AW'(link_i.pos);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_en) begin
      mem[AW'(ctrl_i.wr_addr)] <= ctrl_i.wr_data;
    end
    rdata_q <= mem[raddr];
    pos_q   <= link_i.pos;
    step_q  <= step_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= link_i.valid;
    end
  end

  // take the jump of this level only when its step bit is set
  assign link_o.valid = valid_q;
  assign link_o.pos   = step_q ? rdata_q : pos_q;
  assign rdata_o      = rdata_q;

endmodule

FILE: rtl/kth_successor_binary_lifting.sv
// k-th successor unit for a functional graph, by binary lifting.
// Input channel (in_valid_i / in_stall_o / in_data_i) carries one item:
//   write: stores the successor of a node in level 0 (if both in range; no result);
//   build: fills levels 1..LEVELS-1, reading twice and then writing for
//          each node of each level (ST_RD1, ST_RD2, ST_WR), no result;
//   query: walks the row of level cells, one cell per cycle; the result
//          item is taken from the last cell and registered at the output.
//          A bad start node gives an error item the cycle after acceptance.
// One item is worked on at a time; in_stall_o is high while busy, and a
// query is also held off while an earlier result is stalled at the output.
// Output channel (out_valid_o / out_stall_i / out_data_o) is registered;
// a stalled result stays put until taken.
// Configuration channel (cfg_valid_i / cfg_ready_o / cfg_data_i) writes the
// node count; write it only while idle. Reset clears control state and sets
// the count to 1024; the jump table is undefined until written.
// Each level cell owns one memory of MAX_NODES entries; its single read
// port sets the pace of both query and build.
module kth_successor_binary_lifting #(
  parameter int unsigned MAX_NODES = kthsucc_pkg::DefMaxNodes,
  parameter int unsigned LEVELS    = kthsucc_pkg::DefLevels
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  kthsucc_pkg::in_item_t                 in_data_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output kthsucc_pkg::out_item_t                out_data_o,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [kthsucc_pkg::CountW-1:0]        cfg_data_i
);

  localparam int unsigned NW  = kthsucc_pkg::NodeW;
  localparam int unsigned CW  = kthsucc_pkg::CountW;
  localparam int unsigned LVW = (LEVELS > 1) ? $clog2(LEVELS) : 1;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_RD1  = 5'b00010,
    ST_RD2  = 5'b00100,
    ST_WR   = 5'b01000,
    ST_QRY  = 5'b10000
  } state_e;

  state_e                          state_q, state_d;
  logic [CW-1:0]                   count_q;
  logic [CW-1:0]                   count_eff;
  logic [NW-1:0]                   j_q, j_d;
  logic [LVW-1:0]                  lv_q, lv_d;
  logic [NW-1:0]                   pos_q, pos_d;
  logic [kthsucc_pkg::StepW-1:0]   k_q, k_d;
  logic                            inj_q, inj_d;
  logic                            out_valid_q;
  kthsucc_pkg::out_item_t          out_q;
  logic                            res_valid;
  kthsucc_pkg::out_item_t          res;
  logic                            accept;
  logic                            out_busy;
  logic [LVW-1:0]                  prev_lv;
  logic [NW-1:0]                   bld_addr;
  logic                            last_node;

  kthsucc_pkg::link_t              link [LEVELS+1];
  kthsucc_pkg::cell_ctrl_t         ctrl [LEVELS];
  logic [NW-1:0]                   rdata [LEVELS];

  // count in effect: a value above MAX_NODES acts as MAX_NODES
  assign count_eff = (32'(count_q) > 32'(MAX_NODES)) ? CW'(MAX_NODES) : count_q;

  assign out_busy   = out_valid_q & out_stall_i;
  assign in_stall_o = (state_q != ST_IDLE) ||
                      (out_busy && (in_data_i.operation == kthsucc_pkg::OP_QUERY));
  assign accept     = in_valid_i & ~in_stall_o;
  assign cfg_ready_o = 1'b1;

  assign prev_lv   = LVW'(lv_q - 1'b1);
  assign last_node = ({1'b0, j_q} == CW'(count_eff - 1'b1));
  assign bld_addr  = (state_q == ST_RD2) ? rdata[prev_lv] : j_q;

  always_comb begin
    state_d   = state_q;
    j_d       = j_q;
    lv_d      = lv_q;
    pos_d     = pos_q;
    k_d       = k_q;
    inj_d     = 1'b0;
    res_valid = 1'b0;
    res       = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (in_data_i.operation)
            kthsucc_pkg::OP_BUILD: begin
              j_d  = '0;
              lv_d = LVW'(1);
              if ((LEVELS > 1) && (count_eff != '0)) begin
                state_d = ST_RD1;
              end
            end
            kthsucc_pkg::OP_QUERY: begin
              if ({1'b0, in_data_i.node_index} >= count_eff) begin
                res_valid       = 1'b1;
                res.index_error = 1'b1;
              end else begin
                pos_d   = in_data_i.node_index;
                k_d     = in_data_i.step_count;
                inj_d   = 1'b1;
                state_d = ST_QRY;
              end
            end
            default: ;
          endcase
        end
      end
      ST_RD1: state_d = ST_RD2;
      ST_RD2: state_d = ST_WR;
      ST_WR: begin
        if (last_node) begin
          j_d = '0;
          if (32'(lv_q) == 32'(LEVELS - 1)) begin
            state_d = ST_IDLE;
          end else begin
            lv_d    = LVW'(lv_q + 1'b1);
            state_d = ST_RD1;
          end
        end else begin
          j_d     = NW'(j_q + 1'b1);
          state_d = ST_RD1;
        end
      end
      ST_QRY: begin
        if (link[LEVELS].valid) begin
          res_valid            = 1'b1;
          res.destination_node = link[LEVELS].pos;
          state_d              = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= kthsucc_pkg::CountReset;
      inj_q       <= 1'b0;
      out_valid_q <= 1'b0;
      j_q         <= '0;
      lv_q        <= '0;
    end else begin
      state_q <= state_d;
      inj_q   <= inj_d;
      j_q     <= j_d;
      lv_q    <= lv_d;
      if (cfg_valid_i) begin
        count_q <= cfg_data_i;
      end
      if (res_valid) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q <= pos_d;
    k_q   <= k_d;
    if (res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // query enters the first cell the cycle after acceptance
  assign link[0].valid = inj_q;
  assign link[0].pos   = pos_q;

  for (genvar i = 0; i < LEVELS; i++) begin : g_cell
    logic step_bit;
    if (i < kthsucc_pkg::StepW) begin : g_bit
      assign step_bit = k_q[i];
    end else begin : g_nobit
      assign step_bit = 1'b0;
    end

    always_comb begin
      ctrl[i].bld_sel  = ((state_q == ST_RD1) || (state_q == ST_RD2)) &&
                         (32'(prev_lv) == 32'(i));
      ctrl[i].bld_addr = bld_addr;
      ctrl[i].wr_addr  = (state_q == ST_WR) ? j_q : in_data_i.node_index;
      ctrl[i].wr_data  = (state_q == ST_WR) ? rdata[prev_lv] : in_data_i.successor_node;
      if (i == 0) begin
        ctrl[i].wr_en = accept && (state_q == ST_IDLE) &&
                        (in_data_i.operation == kthsucc_pkg::OP_WRITE) &&
                        ({1'b0, in_data_i.node_index} < count_eff) &&
                        ({1'b0, in_data_i.successor_node} < count_eff);
      end else begin
        ctrl[i].wr_en = (state_q == ST_WR) && (32'(lv_q) == 32'(i));
      end
    end

    kthsucc_cell #(
      .MAX_NODES(MAX_NODES)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .link_i (link[i]),
      .step_i (step_bit),
      .ctrl_i (ctrl[i]),
      .link_o (link[i+1]),
      .rdata_o(rdata[i])
    );
  end

endmodule

FILE: verif/tb.sv
`timescale 1ns / 100ps

module tb;

  localparam int unsigned Levels   = 31;
  localparam int unsigned Nodes    = 1024;
  localparam int unsigned Idle_Max = 30000;  // cycles with no handshake at all
  localparam int unsigned Target   = 950;    // working items to send
  localparam int unsigned Calm_At  = 800;    // no idling from here on

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

  typedef struct {
    row_kind_e              kind;
    kthsucc_pkg::in_item_t  item;
    logic [10:0]            count;
    bit                     typed;
    kthsucc_pkg::out_item_t want;
  } row_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   in_valid_i = 1'b0;
  logic                   in_stall_o;
  kthsucc_pkg::in_item_t  in_data_i = '0;
  logic                   out_valid_o;
  logic                   out_stall_i = 1'b0;
  kthsucc_pkg::out_item_t out_data_o;
  logic                   cfg_valid_i = 1'b0;
  logic                   cfg_ready_o;
  logic [10:0]            cfg_data_i = '0;

  // predictor state: own copy of the lifting table and the node count
  logic [9:0]             lift [Levels][Nodes];
  int unsigned            node_cnt = 1024;
  kthsucc_pkg::out_item_t dest_q[$];
  row_t                   rows[$];

  int unsigned errors = 0;
  int unsigned results_seen = 0;
  int unsigned items_done = 0;
  int unsigned idle_cycles = 0;
  int unsigned settle_cycles = 60;
  bit          calm = 1'b0;
  bit          held_long = 1'b0;
  int unsigned stall_left = 0;
  int unsigned free_left = 0;

  always #5 clk_i = ~clk_i;

  kth_successor_binary_lifting u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i)
  );

  function automatic int unsigned eff_count();
    return (node_cnt > Nodes) ? Nodes : node_cnt;
  endfunction

  // Works out the effect of one accepted item; queries queue their result.
  // A typed expectation, where given, replaces the computed one.
  task automatic predict_walk(input kthsucc_pkg::in_item_t it, input bit typed,
                              input kthsucc_pkg::out_item_t want);
    int unsigned            eff;
    kthsucc_pkg::out_item_t res;
    logic [9:0]             pos;
    eff = eff_count();
    settle_cycles = 60;
    case (kthsucc_pkg::op_e'(it.operation))
      kthsucc_pkg::OP_WRITE: begin
        if (it.node_index < eff && it.successor_node < eff)
          lift[0][it.node_index] = it.successor_node;
      end
      kthsucc_pkg::OP_BUILD: begin
        for (int lv = 1; lv < Levels; lv++)
          for (int j = 0; j < eff; j++)
            lift[lv][j] = lift[lv-1][lift[lv-1][j]];
        settle_cycles = 90 * eff + 60;  // wait out the read, read, write steps for each node of each level
      end
      kthsucc_pkg::OP_QUERY: begin
        if (it.node_index >= eff) begin
          res.destination_node = '0;
          res.index_error = 1'b1;
        end else begin
          pos = it.node_index;
          for (int lv = 0; lv < Levels; lv++)
            if (it.step_count[lv]) pos = lift[lv][pos];
          res.destination_node = pos;
          res.index_error = 1'b0;
        end
        dest_q.push_back(typed ? want : res);
      end
      default: ;
    endcase
  endtask

  task automatic send(input kthsucc_pkg::in_item_t it, input bit typed = 1'b0,
                      input kthsucc_pkg::out_item_t want = '0);
    in_data_i  <= it;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    predict_walk(it, typed, want);
    if (kthsucc_pkg::op_e'(it.operation) == kthsucc_pkg::OP_QUERY ||
        kthsucc_pkg::op_e'(it.operation) == kthsucc_pkg::OP_BUILD ||
        (kthsucc_pkg::op_e'(it.operation) == kthsucc_pkg::OP_WRITE &&
         it.node_index < eff_count() && it.successor_node < eff_count()))
      items_done++;
    calm = (items_done >= Calm_At);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  endtask

  // Only touch the register once the block has gone quiet.
  task automatic set_count(input logic [10:0] value);
    in_valid_i <= 1'b0;
    while (dest_q.size() != 0) @(posedge clk_i);
    repeat (settle_cycles) @(posedge clk_i);
    cfg_data_i  <= value;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    node_cnt = value;
  endtask

  function automatic kthsucc_pkg::in_item_t mk(kthsucc_pkg::op_e op, int unsigned node,
                                               int unsigned succ, logic [30:0] k);
    kthsucc_pkg::in_item_t it;
    it.operation      = op;
    it.node_index     = node[9:0];
    it.successor_node = succ[9:0];
    it.step_count     = k;
    return it;
  endfunction

  task automatic add_row(input kthsucc_pkg::in_item_t it, input bit typed = 1'b0,
                         input logic [9:0] dst = '0, input logic err = 1'b0);
    row_t r;
    r.kind = ROW_ITEM;
    r.item = it;
    r.count = '0;
    r.typed = typed;
    r.want.destination_node = dst;
    r.want.index_error = err;
    rows.push_back(r);
  endtask

  task automatic add_cfg(input logic [10:0] value);
    row_t r;
    r.kind = ROW_CFG;
    r.item = '0;
    r.count = value;
    r.typed = 1'b0;
    r.want = '0;
    rows.push_back(r);
  endtask

  function automatic logic [30:0] rand_steps();
    if ($urandom_range(0, 3) == 0) return 31'($urandom_range(0, 15));
    return 31'($urandom);
  endfunction

  // One phase: set the count, give every node in use a successor, build,
  // then a random mix. Large counts skip the build and jump only along level 0
  // from nodes written here, or not at all, so no unwritten entry reaches a result.
  task automatic run_phase(input logic [10:0] value);
    int unsigned eff;
    int unsigned pick;
    int unsigned node;
    int unsigned touched[$];
    set_count(value);
    eff = eff_count();
    if (eff == 0) begin
      repeat ($urandom_range(10, 20)) begin
        send(mk(kthsucc_pkg::op_e'($urandom_range(0, 3)), $urandom_range(0, 1023),
                $urandom_range(0, 1023), 31'($urandom)));
      end
    end else if (eff == Nodes) begin
      repeat ($urandom_range(20, 40)) begin
        pick = $urandom_range(0, 99);
        if (pick < 35 || touched.size() == 0) begin
          node = $urandom_range(0, 1023);
          touched.push_back(node);
          send(mk(kthsucc_pkg::OP_WRITE, node, $urandom_range(0, 1023), 31'($urandom)));
        end else if (pick < 75) begin
          send(mk(kthsucc_pkg::OP_QUERY, touched[$urandom_range(0, touched.size() - 1)],
                  $urandom_range(0, 1023), 31'($urandom_range(0, 1))));
        end else if (pick < 90) begin
          send(mk(kthsucc_pkg::OP_QUERY, $urandom_range(0, 1023),
                  $urandom_range(0, 1023), '0));
        end else begin
          send(mk(kthsucc_pkg::OP_NONE, $urandom_range(0, 1023), $urandom_range(0, 1023),
                  31'($urandom)));
        end
      end
    end else begin
      for (int j = 0; j < eff; j++)
        send(mk(kthsucc_pkg::OP_WRITE, j, $urandom_range(0, eff - 1), 31'($urandom)));
      send(mk(kthsucc_pkg::OP_BUILD, $urandom_range(0, 1023), $urandom_range(0, 1023),
              31'($urandom)));
      repeat ($urandom_range(30, 50)) begin
        pick = $urandom_range(0, 99);
        if (pick < 55)
          send(mk(kthsucc_pkg::OP_QUERY, $urandom_range(0, eff - 1),
                  $urandom_range(0, 1023), rand_steps()));
        else if (pick < 70)
          send(mk(kthsucc_pkg::OP_WRITE, $urandom_range(0, eff - 1),
                  $urandom_range(0, eff - 1), 31'($urandom)));
        else if (pick < 78)
          // bad write: at least one side out of range
          if ($urandom_range(0, 1))
            send(mk(kthsucc_pkg::OP_WRITE, $urandom_range(eff, 1023),
                    $urandom_range(0, 1023), '0));
          else
            send(mk(kthsucc_pkg::OP_WRITE, $urandom_range(0, 1023),
                    $urandom_range(eff, 1023), '0));
        else if (pick < 83)
          send(mk(kthsucc_pkg::OP_NONE, $urandom_range(0, 1023), $urandom_range(0, 1023),
                  31'($urandom)));
        else if (pick < 91)
          send(mk(kthsucc_pkg::OP_QUERY, $urandom_range(eff, 1023),
                  $urandom_range(0, 1023), 31'($urandom)));
        else if (pick < 94)
          send(mk(kthsucc_pkg::OP_BUILD, $urandom_range(0, 1023),
                  $urandom_range(0, 1023), 31'($urandom)));
        else
          send(mk(kthsucc_pkg::OP_QUERY, $urandom_range(0, eff - 1), 0, 31'h7FFF_FFFF));
      end
    end
  endtask

  // result checker: oldest expectation first
  always @(posedge clk_i) begin
    kthsucc_pkg::out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen <= results_seen + 1;
      if (dest_q.size() == 0) begin
        errors = errors + 1;
        $display("%0t: unexpected result: expected none, actual dest %0d err %0b",
                 $time, out_data_o.destination_node, out_data_o.index_error);
      end else begin
        want = dest_q.pop_front();
        if (out_data_o.destination_node !== want.destination_node) begin
          errors = errors + 1;
          $display("%0t: destination_node mismatch: expected %0d, actual %0d",
                   $time, want.destination_node, out_data_o.destination_node);
        end
        if (out_data_o.index_error !== want.index_error) begin
          errors = errors + 1;
          $display("%0t: index_error mismatch: expected %0b, actual %0b",
                   $time, want.index_error, out_data_o.index_error);
        end
      end
    end
  end

  // receiver: random stall bursts, one long hold-off to back the block up
  always @(posedge clk_i) begin
    logic nxt;
    nxt = 1'b0;
    if (rst_ni) begin
      if (stall_left == 0 && free_left == 0) begin
        if (!held_long && results_seen >= 60) begin
          held_long = 1'b1;
          stall_left = 300;
        end else if (calm) begin
          free_left = 50;
        end else begin
          stall_left = $urandom_range(0, 2) == 0 ? $urandom_range(1, 12) : 0;
          free_left = $urandom_range(1, 20);
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        nxt = 1'b1;
      end else if (free_left > 0) begin
        free_left--;
      end
    end
    out_stall_i <= nxt;
  end

  // watchdog: any handshake restarts the count
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o) || !rst_ni)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= Idle_Max) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    row_t r;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part, count 1024 after reset
    add_row(mk(kthsucc_pkg::OP_WRITE, 0, 1023, '0));
    add_row(mk(kthsucc_pkg::OP_WRITE, 1023, 0, 31'h7FFF_FFFF));
    add_row(mk(kthsucc_pkg::OP_QUERY, 0, 0, '0), 1'b1, 10'd0, 1'b0);
    add_row(mk(kthsucc_pkg::OP_QUERY, 0, 0, 31'd1), 1'b1, 10'd1023, 1'b0);
    add_row(mk(kthsucc_pkg::OP_QUERY, 1023, 1023, 31'd1), 1'b1, 10'd0, 1'b0);
    add_row(mk(kthsucc_pkg::OP_NONE, 1023, 1023, 31'h7FFF_FFFF));
    // small ring of four
    add_cfg(11'd4);
    add_row(mk(kthsucc_pkg::OP_WRITE, 0, 1, '0));
    add_row(mk(kthsucc_pkg::OP_WRITE, 1, 2, '0));
    add_row(mk(kthsucc_pkg::OP_WRITE, 2, 3, '0));
    add_row(mk(kthsucc_pkg::OP_WRITE, 3, 0, '0));
    add_row(mk(kthsucc_pkg::OP_WRITE, 4, 0, '0));     // node out of range: ignored
    add_row(mk(kthsucc_pkg::OP_WRITE, 0, 5, '0));     // successor out of range: ignored
    add_row(mk(kthsucc_pkg::OP_BUILD, 0, 0, '0));
    add_row(mk(kthsucc_pkg::OP_QUERY, 0, 0, '0), 1'b1, 10'd0, 1'b0);
    add_row(mk(kthsucc_pkg::OP_QUERY, 1, 0, 31'd5));
    add_row(mk(kthsucc_pkg::OP_QUERY, 3, 0, 31'h7FFF_FFFF));
    add_row(mk(kthsucc_pkg::OP_QUERY, 4, 0, 31'd1), 1'b1, 10'd0, 1'b1);
    add_row(mk(kthsucc_pkg::OP_QUERY, 1023, 1023, 31'h7FFF_FFFF), 1'b1, 10'd0, 1'b1);
    // zero count: everything out of range
    add_cfg(11'd0);
    add_row(mk(kthsucc_pkg::OP_QUERY, 0, 0, '0), 1'b1, 10'd0, 1'b1);
    add_row(mk(kthsucc_pkg::OP_WRITE, 0, 0, '0));
    add_row(mk(kthsucc_pkg::OP_BUILD, 0, 0, '0));
    // count above the table size acts as full size, stale entries kept
    add_cfg(11'd2047);
    add_row(mk(kthsucc_pkg::OP_QUERY, 3, 0, 31'd1));
    add_row(mk(kthsucc_pkg::OP_QUERY, 1023, 0, 31'd1));

    foreach (rows[i]) begin
      r = rows[i];
      if (r.kind == ROW_CFG) set_count(r.count);
      else send(r.item, r.typed, r.want);
    end

    run_phase(11'd2047);
    run_phase(11'd1);
    run_phase(11'd1024);
    run_phase(11'd0);
    run_phase(11'd2);
    while (items_done < Target) begin
      case ($urandom_range(0, 19))
        0:       run_phase(11'd0);
        1:       run_phase(11'($urandom_range(1024, 2047)));
        2, 3:    run_phase(11'($urandom_range(25, 64)));
        default: run_phase(11'($urandom_range(1, 24)));
      endcase
    end

    in_valid_i <= 1'b0;
    while (dest_q.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (errors == 0 && dest_q.size() == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule
